// ===== rtl/id_allocator_free_queue_unit_macros.svh =====
// Assertion macros for the identifier allocator.
`ifndef ID_ALLOCATOR_FREE_QUEUE_UNIT_MACROS_SVH
`define ID_ALLOCATOR_FREE_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTH
// checked only outside reset
`define IDAFQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked at every edge, reset included
`define IDAFQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IDAFQ_ASSERT(label, clk, rst, prop, msg)
`define IDAFQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/idafq_pkg.sv =====
// Shared types and constants of the identifier allocator.
package idafq_pkg;

   localparam int ID_W       = 16;
   localparam int FRESH_W    = 17;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int RCOUNT_W   = 3;

   localparam logic [FRESH_W-1:0] FRESH_SPENT = 17'h10000;

   localparam logic ACT_ALLOCATE = 1'b0;
   localparam logic ACT_RELEASE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIQUE_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_ID_0  = 3'd2;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EVAL  = 5'b00010,
      S_FETCH = 5'b00100,
      S_SKIP  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic latch_req;
      logic release_op;
      logic pop;
      logic skip_start;
      logic skip_step;
      logic skip_finish;
      logic fetch_load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_release;
      logic queue_empty;
      logic cand_hit;
      logic out_free;
   } stat_type;

endpackage

// ===== rtl/idafq_ctrl.sv =====
// Sequencer of the identifier allocator: walks one request through its steps.
module idafq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  idafq_pkg::stat_type stat,
   output idafq_pkg::cmd_type  cmd
);
   import idafq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.is_release) begin
               cmd.release_op = 1'b1;
               state_in       = S_EMIT;
            end else if (!stat.queue_empty) begin
               cmd.pop  = 1'b1;
               state_in = S_FETCH;
            end else begin
               cmd.skip_start = 1'b1;
               state_in       = S_SKIP;
            end
         end
         S_FETCH: begin
            cmd.fetch_load = 1'b1;
            state_in       = S_EMIT;
         end
         S_SKIP: begin
            // one reserved value stepped over per cycle
            if (stat.cand_hit) begin
               cmd.skip_step = 1'b1;
            end else begin
               cmd.skip_finish = 1'b1;
               state_in        = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/idafq_dp.sv =====
// Datapath of the identifier allocator: free queue, counter, config and output register.
module idafq_dp #(
   parameter int FREE_DEPTH     = 256,
   parameter int RESERVED_SLOTS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  idafq_pkg::cmd_type                   cmd,
   output idafq_pkg::stat_type                  stat,
   input  logic                                 req_action,
   input  logic [idafq_pkg::ID_W-1:0]           req_release_id,
   input  logic                                 csr_we,
   input  logic [idafq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [idafq_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [idafq_pkg::ID_W-1:0]           rsp_result_id,
   output logic [idafq_pkg::STATUS_W-1:0]       rsp_status
);
   import idafq_pkg::*;

   localparam int PTR_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int CNT_W = $clog2(FREE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FREE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_DEPTH);
   localparam logic [RCOUNT_W-1:0] SLOTS = RCOUNT_W'(RESERVED_SLOTS);

   // configuration
   logic                unique_mode_ff;
   logic [RCOUNT_W-1:0] reserved_count_ff;
   logic [ID_W-1:0]     reserved_id_ff [RESERVED_SLOTS];

   // latched request
   logic            req_action_ff;
   logic [ID_W-1:0] req_id_ff;

   // queue and counter
   logic [ID_W-1:0]    mem [FREE_DEPTH];
   logic [ID_W-1:0]    mem_rd_ff;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [FRESH_W-1:0] next_fresh_ff, next_fresh_in;
   logic [FRESH_W-1:0] cand_ff, cand_in;

   // pending result and output register
   logic [ID_W-1:0]     res_id_ff, res_id_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [RCOUNT_W-1:0]     n_active;
   logic [RESERVED_SLOTS-1:0] slot_hit;
   logic                    queue_full;
   logic                    do_queue;

   always_ff @(posedge clock) begin
      if (reset) begin
         unique_mode_ff    <= 1'b0;
         reserved_count_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_UNIQUE_MODE) begin
            unique_mode_ff <= csr_data[0];
         end
         if (csr_index == CSR_RESERVED_COUNT) begin
            reserved_count_ff <= csr_data[RCOUNT_W-1:0];
         end
      end
   end

   for (genvar g = 0; g < RESERVED_SLOTS; g++) begin : g_slot
      always_ff @(posedge clock) begin
         if (reset) begin
            reserved_id_ff[g] <= '0;
         end else if (csr_we && (csr_index == CSR_RESERVED_ID_0 + CSR_IDX_W'(g))) begin
            reserved_id_ff[g] <= csr_data[ID_W-1:0];
         end
      end
      assign slot_hit[g] = (RCOUNT_W'(g) < n_active) && (reserved_id_ff[g] == cand_ff[ID_W-1:0]);
   end

   assign n_active   = (reserved_count_ff > SLOTS) ? SLOTS : reserved_count_ff;
   assign queue_full = (count_ff == CNT_FULL);
   assign do_queue   = !unique_mode_ff && !queue_full;

   assign stat.is_release  = (req_action_ff == ACT_RELEASE);
   assign stat.queue_empty = (count_ff == '0);
   assign stat.cand_hit    = !cand_ff[FRESH_W-1] && (|slot_hit);
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_action_ff <= req_action;
         req_id_ff     <= req_release_id;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.release_op && do_queue) begin
         mem[tail_ff] <= req_id_ff;
      end
      if (cmd.pop) begin
         mem_rd_ff <= mem[head_ff];
      end
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      next_fresh_in = next_fresh_ff;
      cand_in       = cand_ff;
      res_id_in     = res_id_ff;
      res_status_in = res_status_ff;
      if (cmd.release_op) begin
         res_id_in = req_id_ff;
         if (unique_mode_ff) begin
            res_status_in = ST_IGNORED;
         end else if (queue_full) begin
            res_status_in = ST_FULL;
         end else begin
            res_status_in = ST_QUEUED;
            tail_in       = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
            count_in      = count_ff + 1'b1;
         end
      end
      if (cmd.pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (cmd.fetch_load) begin
         res_id_in     = mem_rd_ff;
         res_status_in = ST_ALLOCATED;
      end
      if (cmd.skip_start) begin
         cand_in = next_fresh_ff;
      end
      if (cmd.skip_step) begin
         cand_in = cand_ff + 1'b1;
      end
      if (cmd.skip_finish) begin
         if (!cand_ff[FRESH_W-1]) begin
            res_id_in     = cand_ff[ID_W-1:0];
            res_status_in = ST_ALLOCATED;
            next_fresh_in = cand_ff + 1'b1;
         end else begin
            res_id_in     = '0;
            res_status_in = ST_EXHAUSTED;
            next_fresh_in = FRESH_SPENT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         next_fresh_ff <= '0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         next_fresh_ff <= next_fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      res_id_ff     <= res_id_in;
      res_status_ff <= res_status_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_id_ff     <= res_id_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== rtl/id_allocator_free_queue_unit.sv =====
// Top level of the identifier allocator with a queue of released identifiers.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_action, req_release_id
//   rsp       out        rsp_valid/rsp_ready  rsp_result_id, rsp_status
//   csr       in         csr_valid/csr_ready  csr_index, csr_data
//
// One request at a time: a release passes IDLE, EVAL and EMIT; an allocate from
// the queue adds FETCH (registered memory read) before EMIT, one from the counter
// adds SKIP to step over reserved values; EMIT fills the output register.
// A new request is taken while the previous result waits in the output register;
// its result then holds until rsp_ready frees that register.
// Synchronous reset; the queue memory needs no clearing, only its pointers and fill count reset.
module id_allocator_free_queue_unit #(
   parameter int FREE_DEPTH     = 256,
   parameter int RESERVED_SLOTS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [idafq_pkg::ID_W-1:0]       req_release_id,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [idafq_pkg::ID_W-1:0]       rsp_result_id,
   output logic [idafq_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [idafq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [idafq_pkg::CSR_DATA_W-1:0] csr_data
);
   import idafq_pkg::*;

`include "id_allocator_free_queue_unit_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   idafq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   idafq_dp #(
      .FREE_DEPTH     (FREE_DEPTH),
      .RESERVED_SLOTS (RESERVED_SLOTS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_action),
      .req_release_id (req_release_id),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status)
   );

   `IDAFQ_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")
   `IDAFQ_ASSERT(a_emit_into_free, clock, reset, cmd.emit |-> (!rsp_valid || rsp_ready), "result overwrote a waiting result")
   `IDAFQ_ASSERT(a_one_step, clock, reset, $onehot0({cmd.release_op, cmd.pop, cmd.skip_start, cmd.fetch_load, cmd.skip_finish}), "two request steps at once")
   `IDAFQ_ASSERT(a_emit_shows, clock, reset, cmd.emit |=> (rsp_valid && req_ready), "emitted result not shown")
   `IDAFQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready), "not idle after reset")

endmodule

// ===== test/id_grant_checker.sv =====
// Checker for the identifier allocator: predicts every result and compares it on arrival.
`timescale 1ns / 1ps
module id_grant_checker #(
   parameter int FREE_DEPTH     = 256,
   parameter int RESERVED_SLOTS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_action,
   input  logic [idafq_pkg::ID_W-1:0]       req_release_id,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [idafq_pkg::ID_W-1:0]       rsp_result_id,
   input  logic [idafq_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [idafq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [idafq_pkg::CSR_DATA_W-1:0] csr_data,
   output int                               fail_count,
   output int                               pending
);
   import idafq_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [STATUS_W-1:0] status;
   } grant_type;

   localparam int ID_SPACE = int'(FRESH_SPENT);

   logic                mode_unique;
   logic [RCOUNT_W-1:0] rsv_count;
   logic [ID_W-1:0]     rsv_id [4];
   int                  fresh_ptr;
   logic [ID_W-1:0]     recycle_mem [FREE_DEPTH];
   int                  recycle_rd;
   int                  recycle_wr;
   int                  recycle_fill;
   grant_type           grants_due [$];
   int                  errors = 0;

   // count above the slot number behaves as all slots
   function automatic bit is_reserved_id(int v);
      int n;
      n = (int'(rsv_count) > RESERVED_SLOTS) ? RESERVED_SLOTS : int'(rsv_count);
      for (int i = 0; i < n; i++)
         if (int'(rsv_id[i]) == v)
            return 1'b1;
      return 1'b0;
   endfunction

   task automatic compute_grant(input logic act, input logic [ID_W-1:0] rel,
                                output grant_type g);
      int cand;
      g.id = rel;
      if (act == ACT_ALLOCATE) begin
         if (recycle_fill > 0) begin
            // queued ids go out as they are, reserved or not
            g.id = recycle_mem[recycle_rd];
            recycle_rd = (recycle_rd + 1) % FREE_DEPTH;
            recycle_fill--;
            g.status = ST_ALLOCATED;
         end else begin
            cand = fresh_ptr;
            for (int k = 0; k <= RESERVED_SLOTS && cand < ID_SPACE && is_reserved_id(cand); k++)
               cand++;
            if (cand < ID_SPACE) begin
               g.id = cand[ID_W-1:0];
               fresh_ptr = cand + 1;
               g.status = ST_ALLOCATED;
            end else begin
               fresh_ptr = ID_SPACE;
               g.id = '0;
               g.status = ST_EXHAUSTED;
            end
         end
      end else if (mode_unique) begin
         g.status = ST_IGNORED;
      end else if (recycle_fill >= FREE_DEPTH) begin
         g.status = ST_FULL;
      end else begin
         recycle_mem[recycle_wr] = rel;
         recycle_wr = (recycle_wr + 1) % FREE_DEPTH;
         recycle_fill++;
         g.status = ST_QUEUED;
      end
   endtask

   always @(posedge clock) begin : watch
      grant_type want;
      grant_type got;
      int        slot;
      if (reset) begin
         mode_unique = 1'b0;
         rsv_count = '0;
         for (int i = 0; i < 4; i++)
            rsv_id[i] = '0;
         fresh_ptr = 0;
         recycle_rd = 0;
         recycle_wr = 0;
         recycle_fill = 0;
         grants_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            slot = int'(csr_index) - int'(CSR_RESERVED_ID_0);
            case (csr_index)
               CSR_UNIQUE_MODE:    mode_unique = csr_data[0];
               CSR_RESERVED_COUNT: rsv_count = csr_data[RCOUNT_W-1:0];
               default: if (slot >= 0 && slot < 4) rsv_id[slot] = csr_data;
            endcase
         end
         // results leave before a request taken at the same edge can be answered
         if (rsp_valid && rsp_ready) begin
            got.id = rsp_result_id;
            got.status = rsp_status;
            if (grants_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected result: expected none, got id %h status %0d",
                        $time, got.id, got.status);
            end else begin
               want = grants_due[0];
               grants_due.delete(0);
               if (got.id !== want.id) begin
                  errors++;
                  $display("%0t: result_id expected %h, got %h", $time, want.id, got.id);
               end
               if (got.status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d, got %0d", $time, want.status,
                           got.status);
               end
            end
         end
         if (req_valid && req_ready) begin
            compute_grant(req_action, req_release_id, want);
            grants_due.insert(grants_due.size(), want);
         end
      end
      pending <= grants_due.size();
      fail_count <= errors;
   end

endmodule

// ===== test/tb.sv =====
// Testbench top: request and register stimulus for the identifier allocator, and the verdict.
`timescale 1ns / 1ps
module tb;
   import idafq_pkg::*;

   localparam int FREE_DEPTH      = 256;
   localparam int RESERVED_SLOTS  = 4;
   localparam int DIRECTED_COUNT  = 15;
   localparam int RANDOM_REQUESTS = 1360;
   localparam int FINAL_RUN       = 60;
   localparam int FILL_SEG        = 2;
   localparam int HOLD_SEG        = 5;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 20;
   // ~1.5k requests under both-side idling, plus one long hold
   localparam int CYCLE_LIMIT     = 500_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_action = ACT_ALLOCATE;
   logic [ID_W-1:0]       req_release_id = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ID_W-1:0]       rsp_result_id;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending;
   bit tx_idling = 1'b1;
   bit rx_idling = 1'b1;
   int hold_ticket = 0;
   int hold_served = 0;
   int rx_wait = 0;
   int requests_sent = 0;
   int cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   id_allocator_free_queue_unit #(
      .FREE_DEPTH     (FREE_DEPTH),
      .RESERVED_SLOTS (RESERVED_SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_release_id (req_release_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   id_grant_checker #(
      .FREE_DEPTH     (FREE_DEPTH),
      .RESERVED_SLOTS (RESERVED_SLOTS)
   ) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_release_id (req_release_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result_id  (rsp_result_id),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   // response side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         rx_wait = LONG_HOLD;
      end else if (rx_wait == 0 && rx_idling && $urandom_range(0, 7) == 0) begin
         rx_wait = $urandom_range(1, 15);
      end
      if (rx_wait > 0) begin
         rx_wait = rx_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [ID_W-1:0] random_id();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return ID_W'($urandom_range(0, 2000));
         default: return ID_W'($urandom);
      endcase
   endfunction

   // valid stays up after accept unless an idle burst follows
   task automatic send_request(input logic act, input logic [ID_W-1:0] rel);
      req_valid <= 1'b1;
      req_action <= act;
      req_release_id <= rel;
      do @(posedge clock); while (req_ready !== 1'b1);
      requests_sent++;
      if (tx_idling && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic set_registers(input logic [CSR_DATA_W-1:0] uniq_word,
                                input logic [CSR_DATA_W-1:0] count_word,
                                input logic [3:0][ID_W-1:0] rsv);
      write_reg(CSR_UNIQUE_MODE, uniq_word);
      write_reg(CSR_RESERVED_COUNT, count_word);
      for (int i = 0; i < 4; i++)
         write_reg(CSR_RESERVED_ID_0 + CSR_IDX_W'(i), rsv[i]);
      csr_valid <= 1'b0;
   endtask

   // stop offering and wait until every request has been answered
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      logic [3:0][ID_W-1:0] rsv;
      int                   seg;
      int                   run_len;
      int                   alloc_pct;
      int                   base;
      logic                 act;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults: plain counter, queue order, release id extremes
      send_request(ACT_ALLOCATE, 16'hFFFF);
      send_request(ACT_RELEASE, 16'hFFFF);
      send_request(ACT_RELEASE, 16'h0000);
      send_request(ACT_ALLOCATE, 16'h0000);
      send_request(ACT_ALLOCATE, 16'hFFFF);
      send_request(ACT_ALLOCATE, 16'h5A5A);
      settle();

      // two reserved values in a row skipped; a reserved id released and reissued
      set_registers(16'd0, 16'd2, {16'd5, 16'hFFFF, 16'd3, 16'd2});
      send_request(ACT_ALLOCATE, 16'h0001);
      send_request(ACT_ALLOCATE, 16'h8000);
      send_request(ACT_RELEASE, 16'd3);
      send_request(ACT_ALLOCATE, 16'h7FFF);
      settle();

      // oversized count: four reserved values in a row
      set_registers(16'd0, 16'd7, {16'd9, 16'd8, 16'd7, 16'd6});
      send_request(ACT_ALLOCATE, 16'h1234);
      send_request(ACT_RELEASE, 16'h0055);
      settle();

      // unique mode: releases echoed, queued ids still handed out
      set_registers(16'd1, 16'd4, {16'd9, 16'd8, 16'd7, 16'd0});
      send_request(ACT_RELEASE, 16'hAAAA);
      send_request(ACT_ALLOCATE, 16'h0000);
      send_request(ACT_ALLOCATE, 16'hFFFF);

      seg = 0;
      while (requests_sent < DIRECTED_COUNT + RANDOM_REQUESTS) begin
         settle();
         base = $urandom_range(0, 800);
         for (int i = 0; i < 4; i++)
            case ($urandom_range(0, 5))
               0:       rsv[i] = ($urandom_range(0, 1) == 0) ? '0 : '1;
               1:       rsv[i] = ID_W'($urandom);
               default: rsv[i] = ID_W'(base + i);
            endcase
         set_registers({15'($urandom), (seg != FILL_SEG) && ($urandom_range(0, 3) == 0)},
                       {13'($urandom), 3'($urandom_range(0, 7))}, rsv);
         tx_idling <= ($urandom_range(0, 3) != 0);
         rx_idling <= ($urandom_range(0, 3) != 0);
         if (seg == FILL_SEG) begin
            // overfill the release queue, then drain it into the counter
            repeat (FREE_DEPTH + 12) send_request(ACT_RELEASE, random_id());
            repeat (FREE_DEPTH + 20) send_request(ACT_ALLOCATE, random_id());
         end else begin
            if (seg == HOLD_SEG)
               hold_ticket <= hold_ticket + 1;
            run_len = $urandom_range(20, 60);
            alloc_pct = $urandom_range(30, 70);
            repeat (run_len) begin
               act = ($urandom_range(1, 100) <= alloc_pct) ? ACT_ALLOCATE : ACT_RELEASE;
               send_request(act, random_id());
            end
         end
         seg++;
      end

      // last stretch at full rate on both sides
      settle();
      set_registers(16'd0, 16'd4, {16'd3, 16'd2, 16'd1, 16'd0});
      tx_idling <= 1'b0;
      rx_idling <= 1'b0;
      repeat (FINAL_RUN) begin
         act = ($urandom_range(0, 1) == 0) ? ACT_ALLOCATE : ACT_RELEASE;
         send_request(act, random_id());
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/idafq_pkg.sv
rtl/idafq_ctrl.sv
rtl/idafq_dp.sv
rtl/id_allocator_free_queue_unit.sv
test/id_grant_checker.sv
test/tb.sv
